FILE: rtl/smsp_pkg.sv
// ----------------------------------------------------------------------------
// smsp_pkg : shared definitions for the serial multi servo pwm block
// widths, reset values, register map and character codes
// ----------------------------------------------------------------------------
package smsp_pkg;

    // servo count and derived slot index width
    localparam int SERVO_SLOTS = 2;
    localparam int SLOT_W      = (SERVO_SLOTS > 1) ? $clog2(SERVO_SLOTS) : 1;

    // field widths
    localparam int PULSE_W  = 8;
    localparam int PERIOD_W = 16;
    localparam int ACC_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int PINS_W   = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // reset values
    localparam logic [PULSE_W-1:0]  MIN_PULSE_RST   = 8'd70;
    localparam logic [PULSE_W-1:0]  MAX_PULSE_RST   = 8'd220;
    localparam logic [PERIOD_W-1:0] SLOT_PERIOD_RST = 16'd1000;
    localparam logic [PULSE_W-1:0]  POSITION_RST    = 8'd70;

    // apb register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_MIN_PULSE   = 2'd0;
    localparam logic [1:0] REG_MAX_PULSE   = 2'd1;
    localparam logic [1:0] REG_SLOT_PERIOD = 2'd2;

    // character codes
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'd57;
    localparam logic [BYTE_W-1:0] CHAR_FLUSH = 8'd102;

    // word kind on the input tuser
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_BYTE = 1'b1;

    localparam logic [ACC_W-1:0] ACC_MAX = '1;

endpackage

FILE: rtl/serial_multi_servo_pwm.sv
// ----------------------------------------------------------------------------
// serial_multi_servo_pwm : time multiplexed servo pulse generator
// servos own slots in turn; decimal commands from serial bytes set positions
// ----------------------------------------------------------------------------
//  channel  | direction | signals                              | word
//  s_axis   | in        | s_tvalid s_tready s_tdata s_tuser    | tick or rx byte
//  m_axis   | out       | m_tvalid m_tready m_tdata            | pins and write info
//  apb      | in        | psel penable pwrite paddr pwdata ... | min, max, period
//
//  one word per cycle unless m_tready stalls: state and output register load
//  at the accept edge; the only loop is the combinational counter/accumulator
//  update. a new word is taken when the output register is empty or its held
//  result is taken in the same cycle. rst_n resets all state asynchronously;
//  a stall on m_tready holds the result and stops input after one held word.
module serial_multi_servo_pwm
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // s_tdata: rx_byte[7:0]
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [smsp_pkg::IN_TDATA_W-1:0]      s_tdata,
    // s_tuser: action[0]
    input  logic                                 s_tuser,
    // m_tdata: pin_levels[1:0], position_written[2], written_servo[3],
    //          written_position[11:4], zero[15:12]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [smsp_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [smsp_pkg::PADDR_W-1:0]         paddr,
    input  logic [smsp_pkg::PDATA_W-1:0]         pwdata,
    output logic [smsp_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);
    import smsp_pkg::*;

    logic [PULSE_W-1:0]  min_pulse_reg;
    logic [PULSE_W-1:0]  max_pulse_reg;
    logic [PERIOD_W-1:0] slot_period_reg;

    logic [PERIOD_W-1:0] slot_counter_reg, slot_counter_next;
    logic [SLOT_W-1:0]   active_slot_reg, active_slot_next;
    logic [PULSE_W-1:0]  active_width_reg, active_width_next;
    logic [PULSE_W-1:0]  servo_positions_reg [SERVO_SLOTS];
    logic [ACC_W-1:0]    number_acc_reg, number_acc_next;
    logic [SLOT_W-1:0]   write_ptr_reg, write_ptr_next;

    logic                out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                accept;
    logic [BYTE_W-1:0]   rx_byte;
    logic [PERIOD_W:0]   count_inc;
    logic [ACC_W+4:0]    acc_mul;
    logic                is_digit;
    logic                is_flush;
    logic [PULSE_W-1:0]  clamped;
    logic [PINS_W-1:0]   pins;
    logic                pos_write;
    logic                cfg_write;

    // apb port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_MIN_PULSE:   prdata = {{(PDATA_W-PULSE_W){1'b0}}, min_pulse_reg};
            REG_MAX_PULSE:   prdata = {{(PDATA_W-PULSE_W){1'b0}}, max_pulse_reg};
            REG_SLOT_PERIOD: prdata = {{(PDATA_W-PERIOD_W){1'b0}}, slot_period_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg   <= MIN_PULSE_RST;
            max_pulse_reg   <= MAX_PULSE_RST;
            slot_period_reg <= SLOT_PERIOD_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_MIN_PULSE:   min_pulse_reg   <= pwdata[PULSE_W-1:0];
                REG_MAX_PULSE:   max_pulse_reg   <= pwdata[PULSE_W-1:0];
                REG_SLOT_PERIOD: slot_period_reg <= pwdata[PERIOD_W-1:0];
                default:         ;
            endcase
        end
    end

    // handshake: output register frees when taken
    assign s_tready = ~out_valid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign rx_byte  = s_tdata[BYTE_W-1:0];
    assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign is_flush = (rx_byte == CHAR_FLUSH);
    assign count_inc = {1'b0, slot_counter_reg} + {{PERIOD_W{1'b0}}, 1'b1};
    // acc * 10 + digit as shifts and adds
    assign acc_mul = {2'b00, number_acc_reg, 3'b000}
                   + {4'b0000, number_acc_reg, 1'b0}
                   + {{(ACC_W+1){1'b0}}, rx_byte[3:0] - CHAR_ZERO[3:0]};

    // clamp of the accumulator, max checked first
    always_comb
    begin
        priority if (number_acc_reg > {{(ACC_W-PULSE_W){1'b0}}, max_pulse_reg})
            clamped = max_pulse_reg;
        else if (number_acc_reg < {{(ACC_W-PULSE_W){1'b0}}, min_pulse_reg})
            clamped = min_pulse_reg;
        else
            clamped = number_acc_reg[PULSE_W-1:0];
    end

    // next state of timer and command path
    always_comb
    begin
        slot_counter_next = slot_counter_reg;
        active_slot_next  = active_slot_reg;
        active_width_next = active_width_reg;
        number_acc_next   = number_acc_reg;
        write_ptr_next    = write_ptr_reg;
        pos_write         = 1'b0;
        if (s_tuser == ACT_TICK)
        begin
            if (count_inc >= {1'b0, slot_period_reg})
            begin
                slot_counter_next = '0;
                if (active_slot_reg == SLOT_W'(SERVO_SLOTS - 1))
                    active_slot_next = '0;
                else
                    active_slot_next = active_slot_reg + SLOT_W'(1);
                active_width_next = servo_positions_reg[active_slot_next];
            end
            else
            begin
                slot_counter_next = count_inc[PERIOD_W-1:0];
            end
        end
        else if (is_digit)
        begin
            if (acc_mul > {5'b00000, ACC_MAX})
                number_acc_next = ACC_MAX;
            else
                number_acc_next = acc_mul[ACC_W-1:0];
        end
        else if (is_flush)
        begin
            pos_write       = 1'b1;
            number_acc_next = '0;
            if (write_ptr_reg == SLOT_W'(SERVO_SLOTS - 1))
                write_ptr_next = '0;
            else
                write_ptr_next = write_ptr_reg + SLOT_W'(1);
        end
    end

    // pin decode from the updated slot state
    always_comb
    begin
        pins = '0;
        if (slot_counter_next < {{(PERIOD_W-PULSE_W){1'b0}}, active_width_next})
            pins = PINS_W'(1) << active_slot_next;
    end

    always_comb
    begin
        out_data_next        = '0;
        out_data_next[1:0]   = pins;
        out_data_next[2]     = pos_write;
        out_data_next[3]     = pos_write & write_ptr_reg[0];
        out_data_next[11:4]  = pos_write ? clamped : '0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_counter_reg <= '0;
            active_slot_reg  <= '0;
            active_width_reg <= POSITION_RST;
            number_acc_reg   <= '0;
            write_ptr_reg    <= '0;
            for (int i = 0; i < SERVO_SLOTS; i++)
                servo_positions_reg[i] <= POSITION_RST;
        end
        else if (accept)
        begin
            slot_counter_reg <= slot_counter_next;
            active_slot_reg  <= active_slot_next;
            active_width_reg <= active_width_next;
            number_acc_reg   <= number_acc_next;
            write_ptr_reg    <= write_ptr_next;
            if (pos_write)
                servo_positions_reg[write_ptr_reg] <= clamped;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_tready)
            out_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_data_reg <= '0;
        else if (accept)
            out_data_reg <= out_data_next;
    end

endmodule

FILE: verif/serial_multi_servo_pwm_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_multi_servo_pwm_tb : self-checking bench for the servo pwm block
// drives timer ticks and serial bytes on the input stream, predicts every
// output word with a behavioral copy of the slot timer and command parser,
// and checks each word field by field; apb writes move through several
// register settings, extremes included, with random idling on both streams
// ----------------------------------------------------------------------------
module serial_multi_servo_pwm_tb;
    import smsp_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    typedef struct {
        logic [PINS_W-1:0]  pins;
        logic               written;
        logic [SLOT_W-1:0]  servo;
        logic [PULSE_W-1:0] position;
    } servo_result_t;

    // dut connections
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;    // rx_byte[7:0]
    logic                   s_tuser = 1'b0;  // action[0]
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    // m_tdata: pin_levels[1:0], position_written[2], written_servo[3],
    //          written_position[11:4], zero[15:12]
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    // servo model state and register copy
    logic [PULSE_W-1:0]  cfg_min;
    logic [PULSE_W-1:0]  cfg_max;
    logic [PERIOD_W-1:0] cfg_period;
    logic [16:0]         tick_count;
    int unsigned         live_slot;
    logic [PULSE_W-1:0]  live_width;
    logic [PULSE_W-1:0]  servo_width [SERVO_SLOTS];
    int unsigned         digit_value;
    int unsigned         next_servo;

    servo_result_t expected_words [$];
    servo_result_t want;

    int errors = 0;
    int items_sent = 0;
    int words_checked = 0;
    int positions_stored = 0;
    int registers_written = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    serial_multi_servo_pwm dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    // state after reset
    function automatic void reset_servo_model();
        cfg_min     = MIN_PULSE_RST;
        cfg_max     = MAX_PULSE_RST;
        cfg_period  = SLOT_PERIOD_RST;
        tick_count  = '0;
        live_slot   = 0;
        live_width  = POSITION_RST;
        digit_value = 0;
        next_servo  = 0;
        for (int i = 0; i < SERVO_SLOTS; i++)
        begin
            servo_width[i] = POSITION_RST;
        end
    endfunction

    function automatic int unsigned next_slot_of(input int unsigned i);
        return (i + 1 >= SERVO_SLOTS) ? 0 : i + 1;
    endfunction

    // advance the model by one word and return the word the block must emit
    function automatic servo_result_t predict_servo_word(input logic act,
                                                         input logic [7:0] ch);
        servo_result_t r;
        int unsigned   grown;
        r.pins     = '0;
        r.written  = 1'b0;
        r.servo    = '0;
        r.position = '0;
        if (act == ACT_TICK)
        begin
            tick_count = tick_count + 17'd1;
            if (tick_count >= cfg_period)
            begin
                tick_count = '0;
                live_slot  = next_slot_of(live_slot);
                live_width = servo_width[live_slot];
            end
        end
        else if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
        begin
            grown = digit_value * 10 + (ch - CHAR_ZERO);
            digit_value = (grown > 65535) ? 65535 : grown;
        end
        else if (ch == CHAR_FLUSH)
        begin
            if (digit_value > cfg_max)
                r.position = cfg_max;
            else if (digit_value < cfg_min)
                r.position = cfg_min;
            else
                r.position = digit_value[7:0];
            servo_width[next_servo] = r.position;
            r.written   = 1'b1;
            r.servo     = SLOT_W'(next_servo);
            next_servo  = next_slot_of(next_servo);
            digit_value = 0;
            positions_stored++;
        end
        if (tick_count < live_width)
            r.pins = PINS_W'(1 << live_slot);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val != got_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, got_val);
            errors++;
        end
    endtask

    // one stream word, with random idle cycles ahead of it
    task automatic send_word(input logic act, input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= ch;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_words.push_back(predict_servo_word(act, ch));
        items_sent++;
    endtask

    // hold the sender off until every predicted word has come out
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic tick_burst(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_word(ACT_TICK, 8'($urandom_range(0, 255)));
        end
    endtask

    // decimal digits then the flush byte, ticks mixed in if asked
    task automatic send_number(input int unsigned value, input bit with_ticks);
        int unsigned digits [$];
        int unsigned rest;
        rest = value;
        do
        begin
            digits.push_front(rest % 10);
            rest = rest / 10;
        end
        while (rest != 0);
        if (with_ticks && $urandom_range(4) == 0)
            digits.push_front(0);
        foreach (digits[i])
        begin
            send_word(ACT_BYTE, 8'(CHAR_ZERO + digits[i]));
            if (with_ticks && $urandom_range(9) == 0)
                tick_burst($urandom_range(1, 3));
        end
        send_word(ACT_BYTE, CHAR_FLUSH);
    endtask

    // one apb transfer, after which the bus returns to idle
    task automatic apb_access(input logic is_write, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_register(input logic [1:0] idx);
        logic [31:0] rd;
        apb_access(1'b0, idx, '0, rd);
        case (idx)
            REG_MIN_PULSE:   check_field("min_pulse", cfg_min, rd);
            REG_MAX_PULSE:   check_field("max_pulse", cfg_max, rd);
            default:         check_field("slot_period", cfg_period, rd);
        endcase
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_access(1'b1, idx, value, rd);
        case (idx)
            REG_MIN_PULSE:   cfg_min = value[PULSE_W-1:0];
            REG_MAX_PULSE:   cfg_max = value[PULSE_W-1:0];
            default:         cfg_period = value[PERIOD_W-1:0];
        endcase
        registers_written++;
        check_register(idx);
    endtask

    task automatic set_config(input int unsigned min_p, input int unsigned max_p,
                              input int unsigned period);
        wait_for_results();
        write_register(REG_MIN_PULSE, min_p);
        write_register(REG_MAX_PULSE, max_p);
        write_register(REG_SLOT_PERIOD, period);
    endtask

    function automatic int unsigned pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(0, 300);
        else if (r < 85)
            return $urandom_range(0, 65535);
        else if (r < 93)
            return $urandom_range(65536, 9999999);
        else if (r < 96)
            return cfg_min + $urandom_range(0, 2) - 1;
        else
            return cfg_max + $urandom_range(0, 2) - 1;
    endfunction

    task automatic test_register_defaults();
        check_register(REG_MIN_PULSE);
        check_register(REG_MAX_PULSE);
        check_register(REG_SLOT_PERIOD);
    endtask

    // byte extremes, ignored bytes, clamp at min, saturation, plain store
    task automatic test_directed_commands();
        send_word(ACT_TICK, 8'hFF);
        send_word(ACT_BYTE, 8'h00);
        send_word(ACT_BYTE, 8'hFF);
        send_word(ACT_BYTE, CHAR_ZERO - 8'd1);
        send_word(ACT_BYTE, CHAR_NINE + 8'd1);
        send_number(0, 1'b0);
        send_number(999999, 1'b0);
        send_number(150, 1'b0);
    endtask

    // zero width, width past the period, shrinking period, zero period, min over max
    task automatic test_slot_cases();
        set_config(0, 255, 3);
        send_number(0, 1'b0);
        send_number(255, 1'b0);
        tick_burst(7);
        set_config(0, 255, 50);
        tick_burst(10);
        set_config(0, 255, 4);
        tick_burst(2);
        set_config(0, 255, 0);
        tick_burst(3);
        set_config(200, 100, 4);
        send_number(150, 1'b0);
        send_number(50, 1'b0);
        tick_burst(2);
    endtask

    // mostly well formed commands and tick runs, some noise and stray flushes
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int target;
        int r;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            r = $urandom_range(99);
            if (r < 50)
                tick_burst($urandom_range(1, 12));
            else if (r < 85)
                send_number(pick_value(), 1'b1);
            else if (r < 93)
                send_word(ACT_BYTE, 8'($urandom_range(0, 255)));
            else if (r < 97)
                send_word(ACT_BYTE, CHAR_FLUSH);
            else if (r < 98)
                wait_for_results();
            else
                send_word(ACT_BYTE, 8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
        end
        wait_for_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // receiver stalls
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word %h", m_tdata);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("pin_levels", want.pins, m_tdata[1:0]);
                check_field("position_written", want.written, m_tdata[2]);
                check_field("written_servo", want.servo, m_tdata[3]);
                check_field("written_position", want.position, m_tdata[11:4]);
                check_field("tdata padding", 0, m_tdata[15:12]);
                words_checked++;
            end
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        reset_servo_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_directed_commands();
        test_slot_cases();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_config(0, 255, 17);
                1: set_config(255, 0, 5);
                2: set_config(10, 40, 65535);
                3: set_config(0, 0, 2);
                4: set_config(70, 220, 1000);
                5: set_config(3, 12, 9);
                6: set_config($urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(1, 64));
                default: set_config(0, 255, 1);
            endcase
            case (p % 4)
                0: test_random_traffic(190, 0, 0);
                1: test_random_traffic(190, 85, 0);
                2: test_random_traffic(190, 0, 85);
                default: test_random_traffic(190, 11, 11);
            endcase
        end

        wait_for_results();
        repeat (8) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            $error("%0d result words never arrived", expected_words.size());
            errors++;
        end

        $display("run: %0d words sent, %0d result words checked, %0d positions stored",
                 items_sent, words_checked, positions_stored);
        $display("run: %0d register writes over 8 settings and 4 idle patterns",
                 registers_written);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
